// ===== rtl/swm_pkg.sv =====
// Shared types, character constants and helpers for the star wildcard matcher.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package swm_pkg;

   // Default number of pattern cells.
   localparam int PATTERN_MAX_DEF = 32;

   // Character constants.
   localparam logic [7:0] STAR_CHAR   = 8'h2A;
   localparam logic [7:0] UPPER_A     = 8'h41;
   localparam logic [7:0] UPPER_Z     = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] NUL_CHAR    = 8'h00;

   // Transaction opcodes.
   localparam logic OP_PATTERN = 1'b0;
   localparam logic OP_TEXT    = 1'b1;

   // Register indexes, decoded from the word address.
   localparam logic CSR_CASE_SENSITIVE = 1'b0;
   localparam logic CSR_ALT_TERMINATOR = 1'b1;

   // Configuration register contents.
   typedef struct packed {
      logic       case_sensitive;
      logic [7:0] alt_terminator;
   } cfg_type;

   // Per-transaction control broadcast to every cell.
   typedef struct packed {
      logic       load;      // pattern transaction accepted
      logic       clr;       // that transaction starts a fresh pattern
      logic       wr;        // the character is stored at the first free cell
      logic       restart;   // text transaction with last: back to the start set
      logic       consume;   // text character advances the active set
      logic       fold_en;   // fold A-Z to lower case
      logic [7:0] ch;        // character of the transaction
   } cell_ctrl_type;

   // Signals handed from one cell to its right-hand neighbor.
   typedef struct packed {
      logic valid;   // this cell holds a pattern character (after any clear)
      logic step;    // literal match moves activity to the next position
      logic close;   // star closure carries activity to the next position
      logic spush;   // start-set bit pushed by a star written here
   } cell_link_type;

   // Fold an upper-case letter to lower case when enabled.
   function automatic logic [7:0] fold_char(input logic [7:0] c, input logic fold_en);
      logic [7:0] r;
      r = c;
      if (fold_en && c >= UPPER_A && c <= UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/swm_cell.sv =====
// One pattern position of the matcher: stored character, fill bit, start-set bit
// and active bit. Depends on swm_pkg for the control and link types.
`default_nettype none

module swm_cell
   import swm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          head,
   input  wire cell_ctrl_type ctrl,
   input  wire cell_link_type link_in,
   output cell_link_type      link_out,
   output logic               hit,
   output logic               hold
);

   logic [7:0] pat_ff;
   logic       valid_ff;
   logic       start_ff;
   logic       active_ff;

   logic valid_e;
   logic is_star;
   logic we;
   logic start_new;
   logic eq;
   logic nxt;
   logic closed;

   // Fill state after a possible pattern clear; the first free cell takes the write.
   assign valid_e   = valid_ff & ~ctrl.clr;
   assign is_star   = (pat_ff == STAR_CHAR);
   assign we        = ctrl.wr & link_in.valid & ~valid_e;
   assign start_new = (start_ff & ~ctrl.clr) | link_in.spush;

   // Advance on a text character, then close over stars from the left.
   assign eq     = (fold_char(pat_ff, ctrl.fold_en) == fold_char(ctrl.ch, ctrl.fold_en));
   assign nxt    = (active_ff & is_star & valid_ff) | link_in.step;
   assign closed = nxt | link_in.close;

   // Hand-off to the neighbor.
   assign link_out.valid = valid_e;
   assign link_out.step  = active_ff & valid_ff & ~is_star & eq;
   assign link_out.close = closed & is_star & valid_ff;
   assign link_out.spush = we & start_new & (ctrl.ch == STAR_CHAR);

   // This position is the pattern end when the left cell is filled and this one is not.
   assign hit  = closed & link_in.valid & ~valid_ff;
   assign hold = active_ff & link_in.valid & ~valid_ff;

   // Pattern character; written once per fill, needs no reset.
   always_ff @(posedge clock) begin
      if (ctrl.load && we) begin
         pat_ff <= ctrl.ch;
      end
   end

   // Fill, start-set and active bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         start_ff  <= head;
         active_ff <= head;
      end else if (ctrl.load) begin
         valid_ff  <= valid_e | we;
         start_ff  <= start_new;
         active_ff <= start_new;
      end else if (ctrl.restart) begin
         active_ff <= start_ff;
      end else if (ctrl.consume) begin
         active_ff <= closed;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/swm_csr.sv =====
// Configuration registers of the matcher behind an APB-style port.
// Depends on swm_pkg for the register indexes and the cfg_type struct.
`default_nettype none

module swm_csr
   import swm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign cfg    = cfg_ff;

   // Register writes complete in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.case_sensitive <= 1'b1;
         cfg_ff.alt_terminator <= NUL_CHAR;
      end else if (wr_en) begin
         case (paddr[2])
            CSR_CASE_SENSITIVE: cfg_ff.case_sensitive <= pwdata[0];
            CSR_ALT_TERMINATOR: cfg_ff.alt_terminator <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read data.
   always_comb begin
      case (paddr[2])
         CSR_CASE_SENSITIVE: prdata = {31'd0, cfg_ff.case_sensitive};
         CSR_ALT_TERMINATOR: prdata = {24'd0, cfg_ff.alt_terminator};
         default:            prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/star_wildcard_matcher.sv =====
// Top level of the star-only wildcard matcher: a row of pattern cells, the
// configuration registers and the result register. Uses swm_pkg, swm_cell, swm_csr.
//
//   channel | ports                                   | direction
//   req     | req_valid/ready, req_op, req_ch, req_last | in: pattern or text character
//   rsp     | rsp_valid/ready, rsp_matched, rsp_text_done, rsp_pattern_overflow | out
//   csr     | psel, penable, pwrite, paddr, pwdata, prdata, pready | register access
//
// One transaction may be accepted on each clock edge while the result register frees.
// The verdict is computed as the active bits ripple through the cell row and is
// registered, so it appears on the cycle after the text transaction is accepted.
// Pattern transactions give no result. Reset is synchronous and leaves an empty
// pattern. A stalled result holds the input only until the result register frees.
`default_nettype none

module star_wildcard_matcher
   import swm_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_last,
   // Result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_matched,
   output logic             rsp_text_done,
   output logic             rsp_pattern_overflow,
   // Configuration port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   cfg_type       cfg;
   cell_ctrl_type ctrl;
   cell_link_type links [0:PATTERN_MAX];
   logic [PATTERN_MAX:0] hit_vec;
   logic [PATTERN_MAX:0] hold_vec;

   logic closed_ff;
   logic ended_ff;
   logic overflow_ff;
   logic text_ended_ff;
   logic tail_start_ff;
   logic tail_active_ff;

   logic rsp_valid_ff;
   logic rsp_matched_ff;
   logic rsp_text_done_ff;
   logic rsp_overflow_ff;

   logic accept;
   logic pat_acc;
   logic txt_acc;
   logic end_byte;
   logic clr;
   logic ended_e;
   logic full;
   logic tail_closed;
   logic tail_start_new;
   logic matched_in;

   swm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Handshake: the result register frees when empty or being taken.
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign pat_acc   = accept & (req_op == OP_PATTERN);
   assign txt_acc   = accept & (req_op == OP_TEXT);
   assign end_byte  = (req_ch == NUL_CHAR) || (req_ch == cfg.alt_terminator);

   // Pattern bookkeeping for this transaction.
   assign clr     = pat_acc & closed_ff;
   assign ended_e = ended_ff & ~clr;
   assign full    = links[PATTERN_MAX].valid;

   // Control broadcast to the cells.
   assign ctrl.load    = pat_acc;
   assign ctrl.clr     = clr;
   assign ctrl.wr      = pat_acc & ~ended_e & ~end_byte;
   assign ctrl.restart = txt_acc & req_last;
   assign ctrl.consume = txt_acc & ~text_ended_ff & ~end_byte;
   assign ctrl.fold_en = ~cfg.case_sensitive;
   assign ctrl.ch      = req_ch;

   // Left edge of the row: position zero is always in the start set.
   assign links[0].valid = 1'b1;
   assign links[0].step  = 1'b0;
   assign links[0].close = 1'b0;
   assign links[0].spush = 1'b1;

   // Row of pattern cells.
   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      swm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .head     ((i == 0) ? 1'b1 : 1'b0),
         .ctrl     (ctrl),
         .link_in  (links[i]),
         .link_out (links[i+1]),
         .hit      (hit_vec[i]),
         .hold     (hold_vec[i])
      );
   end

   // Final position past the last cell: reached only when the row is full.
   assign tail_closed    = links[PATTERN_MAX].step | links[PATTERN_MAX].close;
   assign tail_start_new = (tail_start_ff & ~clr) | links[PATTERN_MAX].spush;
   assign hit_vec[PATTERN_MAX]  = tail_closed & full;
   assign hold_vec[PATTERN_MAX] = tail_active_ff & full;

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_start_ff  <= 1'b0;
         tail_active_ff <= 1'b0;
      end else if (pat_acc) begin
         tail_start_ff  <= tail_start_new;
         tail_active_ff <= tail_start_new;
      end else if (ctrl.restart) begin
         tail_active_ff <= tail_start_ff;
      end else if (ctrl.consume) begin
         tail_active_ff <= tail_closed;
      end
   end

   // Pattern and text status flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff     <= 1'b0;
         ended_ff      <= 1'b0;
         overflow_ff   <= 1'b0;
         text_ended_ff <= 1'b0;
      end else if (pat_acc) begin
         closed_ff     <= req_last;
         ended_ff      <= ended_e | end_byte;
         overflow_ff   <= (overflow_ff & ~clr) | (ctrl.wr & full);
         text_ended_ff <= 1'b0;
      end else if (txt_acc) begin
         text_ended_ff <= ~req_last & (text_ended_ff | end_byte);
      end
   end

   // Verdict: the end position after the step, or as held when nothing is consumed.
   assign matched_in = ctrl.consume ? (|hit_vec) : (|hold_vec);

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (txt_acc) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (txt_acc) begin
         rsp_matched_ff   <= matched_in;
         rsp_text_done_ff <= req_last;
         rsp_overflow_ff  <= overflow_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_text_done        = rsp_text_done_ff;
   assign rsp_pattern_overflow = rsp_overflow_ff;

endmodule

`default_nettype wire

// ===== test/tb_star_wildcard_matcher.sv =====
// Self-checking testbench for star_wildcard_matcher: a directed table, then random pattern
// and text transactions under several register settings, checked against a local glob model.
// Depends on swm_pkg and the star_wildcard_matcher RTL only.
module tb_star_wildcard_matcher
   import swm_pkg::*;
();

   localparam int PMAX       = PATTERN_MAX_DEF;
   localparam int IDLE_LIMIT = 2000;
   localparam int LONG_HOLD  = 300;
   localparam int PHASES     = 6;
   localparam int PHASE_LEN  = 180;

   // One result transaction as it appears on the rsp_ ports.
   typedef struct packed {
      logic matched;
      logic done;
      logic ovf;
   } verdict_type;

   // A row of the directed table is either an input transaction or a register write.
   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;
   typedef struct packed {
      row_kind_type kind;
      logic       op;       // opcode, or register index for ROW_CFG
      logic [7:0] ch;       // character, or register value for ROW_CFG
      logic       last;
      logic       typed;    // expected verdict is given in the row
      logic       matched;
      logic       ovf;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = OP_PATTERN;
   logic [7:0]  req_ch = 8'h00;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_matched;
   logic        rsp_text_done;
   logic        rsp_pattern_overflow;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // Expected verdict carried alongside the payload for typed table rows.
   logic        row_typed = 1'b0;
   logic        row_matched = 1'b0;
   logic        row_ovf = 1'b0;

   // Glob model state.
   logic [7:0]  pat_mem [PMAX];
   int          pat_len;
   logic        pat_closed;
   logic        pat_ended;
   logic        pat_ovf;
   logic [PMAX:0] live;
   logic        txt_ended;
   logic        cfg_case;
   logic [7:0]  cfg_term;

   verdict_type verdict_q [$];
   verdict_type new_v;
   verdict_type got_v;
   logic        has_v;
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   int          items_sent = 0;
   logic        hold_rsp = 1'b0;
   logic        steady = 1'b0;

   dir_row_type dir_tab [25] = '{
      '{ROW_ITEM, OP_TEXT,    8'h61, 1'b1, 1'b1, 1'b0, 1'b0},  // text before any pattern
      '{ROW_ITEM, OP_TEXT,    8'h00, 1'b1, 1'b1, 1'b1, 1'b0},  // empty text, empty pattern
      '{ROW_ITEM, OP_PATTERN, 8'h61, 1'b0, 1'b0, 1'b0, 1'b0},  // pattern "a*B"
      '{ROW_ITEM, OP_PATTERN, 8'h2A, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_ITEM, OP_PATTERN, 8'h42, 1'b1, 1'b0, 1'b0, 1'b0},
      '{ROW_ITEM, OP_TEXT,    8'h61, 1'b0, 1'b0, 1'b0, 1'b0},  // text "axB"
      '{ROW_ITEM, OP_TEXT,    8'h78, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_ITEM, OP_TEXT,    8'h42, 1'b1, 1'b0, 1'b0, 1'b0},
      '{ROW_ITEM, OP_TEXT,    8'h62, 1'b1, 1'b0, 1'b0, 1'b0},  // text "b"
      '{ROW_CFG,  CSR_CASE_SENSITIVE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_ITEM, OP_TEXT,    8'h41, 1'b0, 1'b0, 1'b0, 1'b0},  // folded text "Ab"
      '{ROW_ITEM, OP_TEXT,    8'h62, 1'b1, 1'b0, 1'b0, 1'b0},
      '{ROW_CFG,  CSR_ALT_TERMINATOR, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_ITEM, OP_PATTERN, 8'h78, 1'b0, 1'b0, 1'b0, 1'b0},  // pattern "x" ended early
      '{ROW_ITEM, OP_PATTERN, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_ITEM, OP_PATTERN, 8'h79, 1'b1, 1'b0, 1'b0, 1'b0},
      '{ROW_ITEM, OP_TEXT,    8'h58, 1'b0, 1'b0, 1'b0, 1'b0},  // text "X", then terminator
      '{ROW_ITEM, OP_TEXT,    8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_ITEM, OP_TEXT,    8'h71, 1'b1, 1'b0, 1'b0, 1'b0},
      '{ROW_ITEM, OP_PATTERN, 8'h2A, 1'b1, 1'b0, 1'b0, 1'b0},  // pattern "*"
      '{ROW_ITEM, OP_TEXT,    8'h80, 1'b0, 1'b1, 1'b1, 1'b0},
      '{ROW_ITEM, OP_PATTERN, 8'h2A, 1'b0, 1'b0, 1'b0, 1'b0},  // pattern during text
      '{ROW_ITEM, OP_TEXT,    8'h7F, 1'b1, 1'b0, 1'b0, 1'b0},
      '{ROW_CFG,  CSR_CASE_SENSITIVE, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_CFG,  CSR_ALT_TERMINATOR, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0}
   };

   // Register settings of the random phases; extremes of both registers are included.
   logic       phase_case [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
   logic [7:0] phase_term [PHASES] = '{8'h00, 8'h00, 8'h2E, 8'hFF, 8'h2A, 8'h01};

   star_wildcard_matcher DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_ch(req_ch),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_matched(rsp_matched),
      .rsp_text_done(rsp_text_done),
      .rsp_pattern_overflow(rsp_pattern_overflow),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   // Fold an upper-case letter when case folding is enabled.
   function automatic logic [7:0] fold_letter(input logic [7:0] c);
      if (!cfg_case && c >= UPPER_A && c <= UPPER_Z) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

   // Carry activity across every star, left to right so that runs of stars chain.
   function automatic void close_stars();
      for (int i = 0; i < pat_len; i++) begin
         if (live[i] && pat_mem[i] == STAR_CHAR) begin
            live[i+1] = 1'b1;
         end
      end
   endfunction

   function automatic void restart_text();
      live = '0;
      live[0] = 1'b1;
      close_stars();
      txt_ended = 1'b0;
   endfunction

   function automatic logic ends_string(input logic [7:0] c);
      return c == NUL_CHAR || c == cfg_term;
   endfunction

   // Advance the model by one input transaction; a text transaction yields a verdict.
   function automatic void glob_predict(input logic op, input logic [7:0] c, input logic last,
                                        output logic has, output verdict_type v);
      logic [PMAX:0] nxt;
      has = 1'b0;
      v = '0;
      if (op == OP_PATTERN) begin
         if (pat_closed) begin
            pat_len = 0;
            pat_ended = 1'b0;
            pat_ovf = 1'b0;
            pat_closed = 1'b0;
         end
         if (!pat_ended) begin
            if (ends_string(c)) begin
               pat_ended = 1'b1;
            end else if (pat_len < PMAX) begin
               pat_mem[pat_len] = c;
               pat_len++;
            end else begin
               pat_ovf = 1'b1;
            end
         end
         if (last) begin
            pat_closed = 1'b1;
         end
         restart_text();
         return;
      end
      if (!txt_ended) begin
         if (ends_string(c)) begin
            txt_ended = 1'b1;
         end else begin
            nxt = '0;
            for (int i = 0; i < pat_len; i++) begin
               if (live[i]) begin
                  if (pat_mem[i] == STAR_CHAR) begin
                     nxt[i] = 1'b1;
                  end else if (fold_letter(pat_mem[i]) == fold_letter(c)) begin
                     nxt[i+1] = 1'b1;
                  end
               end
            end
            live = nxt;
            close_stars();
         end
      end
      has = 1'b1;
      v.matched = live[pat_len];
      v.done = last;
      v.ovf = pat_ovf;
      if (last) begin
         restart_text();
      end
   endfunction

   task automatic flag_mismatch(input string what, input int expv, input int gotv);
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, expv, gotv);
      mismatch_count++;
   endtask

   // Monitor: register writes, accepted input transactions and accepted results.
   always @(posedge clock) begin
      if (!reset) begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == CSR_CASE_SENSITIVE) begin
               cfg_case = pwdata[0];
            end else begin
               cfg_term = pwdata[7:0];
            end
         end
         if (rsp_valid && rsp_ready) begin
            got_v = '{rsp_matched, rsp_text_done, rsp_pattern_overflow};
            if (verdict_q.size() == 0) begin
               flag_mismatch("result with nothing pending", 0, 1);
            end else begin
               new_v = verdict_q.pop_front();
               if (got_v.matched !== new_v.matched) begin
                  flag_mismatch("rsp_matched", new_v.matched, got_v.matched);
               end
               if (got_v.done !== new_v.done) begin
                  flag_mismatch("rsp_text_done", new_v.done, got_v.done);
               end
               if (got_v.ovf !== new_v.ovf) begin
                  flag_mismatch("rsp_pattern_overflow", new_v.ovf, got_v.ovf);
               end
            end
         end
         if (req_valid && req_ready) begin
            glob_predict(req_op, req_ch, req_last, has_v, new_v);
            if (has_v) begin
               if (row_typed) begin
                  new_v.matched = row_matched;
                  new_v.ovf = row_ovf;
               end
               verdict_q.push_back(new_v);
            end
         end
      end
   end

   // Watchdog: end the run when nothing has been accepted for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (psel && penable)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("star_wildcard_matcher test failed");
            $finish;
         end
      end
   end

   // Result side: random stall bursts, one long hold-off on request, none when steady.
   initial begin
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (steady || $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // Offer one input transaction, after an optional idle burst, and wait for acceptance.
   task automatic offer(input logic op, input logic [7:0] c, input logic last,
                        input logic typed, input logic m, input logic o);
      if (!steady && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_ch <= c;
      req_last <= last;
      row_typed <= typed;
      row_matched <= m;
      row_ovf <= o;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Stop offering and wait until every expected result has arrived.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write, setup phase then access phase, then the port goes idle; the block is idle when called.
   task automatic csr_write(input logic idx, input logic [7:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {24'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Small alphabet so that literals collide often, with stars and the odd arbitrary byte.
   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'h61;
         3:       return 8'h41;
         4, 5:    return 8'h62;
         6:       return 8'h42;
         7:       return STAR_CHAR;
         8:       return 8'($urandom_range(1, 255));
         default: return 8'h63;
      endcase
   endfunction

   function automatic logic [7:0] end_char();
      if (cfg_term != NUL_CHAR && $urandom_range(0, 1) == 1) begin
         return cfg_term;
      end
      return NUL_CHAR;
   endfunction

   // One random sequence: mostly a pattern followed by texts built from it, sometimes noise.
   task automatic random_burst();
      logic [7:0] pat [$];
      logic [7:0] txt [$];
      logic [7:0] c;
      int n;
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 6)) begin
            offer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0);
         end
         return;
      end
      // Mostly short patterns; about one in ten is near or past the store size.
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(PMAX - 4, PMAX + 8) : $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
         pat.push_back(pick_char());
      end
      if (n == 0) begin
         offer(OP_PATTERN, end_char(), 1'b1, 1'b0, 1'b0, 1'b0);
      end else begin
         for (int i = 0; i < n; i++) begin
            offer(OP_PATTERN, pat[i], i == n - 1, 1'b0, 1'b0, 1'b0);
         end
      end
      repeat ($urandom_range(1, 4)) begin
         txt.delete();
         // Expand the pattern so that many texts match, then perturb some of them.
         foreach (pat[i]) begin
            if (pat[i] == STAR_CHAR) begin
               repeat ($urandom_range(0, 3)) txt.push_back(pick_char());
            end else begin
               c = pat[i];
               if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 3) == 0) begin
                  c = c ^ 8'h20;
               end
               txt.push_back(c);
            end
         end
         if (txt.size() > 0 && $urandom_range(0, 3) == 0) begin
            txt[$urandom_range(0, txt.size() - 1)] = pick_char();
         end
         if ($urandom_range(0, 7) == 0) begin
            txt.insert($urandom_range(0, txt.size()), end_char());
         end
         if (txt.size() == 0) begin
            offer(OP_TEXT, end_char(), 1'b1, 1'b0, 1'b0, 1'b0);
         end else begin
            foreach (txt[i]) begin
               offer(OP_TEXT, txt[i], i == txt.size() - 1, 1'b0, 1'b0, 1'b0);
            end
         end
      end
   endtask

   // Main sequence: reset, directed table, random phases, drain and verdict.
   initial begin
      int target;
      cfg_case = 1'b1;
      cfg_term = NUL_CHAR;
      pat_len = 0;
      pat_closed = 1'b0;
      pat_ended = 1'b0;
      pat_ovf = 1'b0;
      restart_text();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[r]) begin
         if (dir_tab[r].kind == ROW_CFG) begin
            settle();
            csr_write(dir_tab[r].op, dir_tab[r].ch);
         end else begin
            offer(dir_tab[r].op, dir_tab[r].ch, dir_tab[r].last,
                  dir_tab[r].typed, dir_tab[r].matched, dir_tab[r].ovf);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         csr_write(CSR_CASE_SENSITIVE, {7'd0, phase_case[ph]});
         csr_write(CSR_ALT_TERMINATOR, phase_term[ph]);
         // The result side holds off once while transactions keep coming.
         if (ph == 2) begin
            hold_rsp = 1'b1;
         end
         // No idling on either side in the final phase.
         if (ph == PHASES - 1) begin
            steady = 1'b1;
         end
         target = items_sent + PHASE_LEN;
         while (items_sent < target) begin
            random_burst();
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("star_wildcard_matcher test passed");
      end else begin
         $display("star_wildcard_matcher test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_csr.sv
rtl/star_wildcard_matcher.sv
test/tb_star_wildcard_matcher.sv
